// ===== src/sptf_pkg.sv =====
package sptf_pkg;

   // input word: one sprite attribute entry with frame marks
   typedef struct packed {
      logic        first_of_frame;
      logic        last_of_frame;
      logic [15:0] attr_y_shape;
      logic [15:0] attr_x_size;
      logic [15:0] attr_tile;
   } req_type;

   // result word
   typedef struct packed {
      logic [1:0] kind;
      logic [8:0] tile_index;
      logic [4:0] tile_slot;
      logic [5:0] tile_total;
      logic       last;
   } rsp_type;

   // result kinds
   localparam logic [1:0] KIND_TILE  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ABORT = 2'd2;

   // attribute decoding
   localparam logic [1:0]  SHAPE_PROHIBITED = 2'd3;
   localparam logic [15:0] SKIP_MASK        = 16'he000;
   localparam logic [15:0] NOCULL_MASK      = 16'h1100;

   // tiles given per item at most
   localparam logic [5:0] TILE_CAP = 6'd32;

   // visible screen in pixels
   localparam logic signed [10:0] SCREEN_W = 11'sd240;
   localparam logic signed [10:0] SCREEN_H = 11'sd160;
   localparam logic [7:0]         Y_FOLD   = 8'd160;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;      // load a new entry
      logic walk_init;   // zero row and column
      logic advance;     // step to the next tile position
      logic set_abort;   // mark the frame aborted
      logic take_tile;   // collect the current tile into the pending stage
      logic push_pend;   // move the pending tile to the output register
      logic push_last;   // last flag for push_pend
      logic push_frame;  // load the frame result into the output register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic aborted;
      logic skip;
      logic bad_shape;
      logic too_big;
      logic lof;
      logic visible;
      logic over_limit;
      logic walk_last;
      logic pend_valid;
      logic out_free;
   } sts_type;

   // sprite width in tiles, indexed by {shape, size}
   function automatic logic [3:0] tile_cols(input logic [3:0] sel);
      logic [3:0] w;
      case (sel)
         4'd0:    w = 4'd1;
         4'd1:    w = 4'd2;
         4'd2:    w = 4'd4;
         4'd3:    w = 4'd8;
         4'd4:    w = 4'd2;
         4'd5:    w = 4'd4;
         4'd6:    w = 4'd4;
         4'd7:    w = 4'd8;
         4'd8:    w = 4'd1;
         4'd9:    w = 4'd1;
         4'd10:   w = 4'd2;
         4'd11:   w = 4'd4;
         default: w = 4'd1;
      endcase
      return w;
   endfunction

   // sprite height in tiles, indexed by {shape, size}
   function automatic logic [3:0] tile_rows(input logic [3:0] sel);
      logic [3:0] h;
      case (sel)
         4'd0:    h = 4'd1;
         4'd1:    h = 4'd2;
         4'd2:    h = 4'd4;
         4'd3:    h = 4'd8;
         4'd4:    h = 4'd1;
         4'd5:    h = 4'd1;
         4'd6:    h = 4'd2;
         4'd7:    h = 4'd4;
         4'd8:    h = 4'd2;
         4'd9:    h = 4'd4;
         4'd10:   h = 4'd4;
         4'd11:   h = 4'd8;
         default: h = 4'd1;
      endcase
      return h;
   endfunction

endpackage

// ===== src/sptf_ctrl.sv =====
module sptf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sptf_pkg::sts_type sts,
   output sptf_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CHECK  = 2'd1;
   localparam logic [1:0] ST_WALK   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.aborted || sts.skip) begin
               state_in = ST_FINISH;
            end else if (sts.bad_shape || sts.too_big) begin
               cmd.set_abort = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.walk_init = 1'b1;
               state_in      = ST_WALK;
            end
         end
         ST_WALK: begin
            if (sts.visible && sts.over_limit) begin
               cmd.set_abort = 1'b1;
               state_in      = ST_FINISH;
            end else if (sts.visible) begin
               // hold while the pending tile cannot move on
               if (!sts.pend_valid || sts.out_free) begin
                  cmd.take_tile = 1'b1;
                  cmd.advance   = 1'b1;
                  if (sts.walk_last) begin
                     state_in = ST_FINISH;
                  end
               end
            end else begin
               cmd.advance = 1'b1;
               if (sts.walk_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (sts.pend_valid) begin
               if (sts.out_free) begin
                  cmd.push_pend = 1'b1;
                  cmd.push_last = !sts.lof;
                  if (!sts.lof) begin
                     state_in = ST_IDLE;
                  end
               end
            end else if (sts.lof) begin
               if (sts.out_free) begin
                  cmd.push_frame = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/sptf_datapath.sv =====
module sptf_datapath #(
   parameter int MAX_TILES  = 32,
   parameter int VRAM_BYTES = 32768
) (
   input  logic              clock,
   input  logic              reset,
   input  sptf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sptf_pkg::rsp_type rsp_data,
   input  sptf_pkg::cmd_type cmd,
   output sptf_pkg::sts_type sts
);

   localparam logic [17:0] VramLimit = 18'(VRAM_BYTES);
   localparam logic [6:0]  TileLimit = 7'(MAX_TILES);

   // entry registers
   logic [15:0] attr_a_ff, attr_b_ff, attr_c_ff;
   logic        lof_ff;

   // frame state
   logic [5:0] count_ff;
   logic       aborted_ff;
   logic [5:0] item_n_ff;

   // walk position
   logic [2:0] row_ff, col_ff;

   // pending tile and output register
   logic              pend_valid_ff;
   logic [8:0]        pend_index_ff;
   logic [4:0]        pend_slot_ff;
   logic              rsp_valid_ff;
   sptf_pkg::rsp_type rsp_data_ff;
   sptf_pkg::rsp_type rsp_data_in;
   logic              push_out;

   // decoded geometry
   logic [3:0]         sel;
   logic [3:0]         cols, rows;
   logic [16:0]        footprint;
   logic [2:0]         hoff, voff;
   logic signed [10:0] x_pos, y_pos, px, py;
   logic               culled;
   logic [6:0]         row_off;
   logic [8:0]         tile_idx;
   logic               out_free;

   assign sel  = {attr_a_ff[15:14], attr_b_ff[15:14]};
   assign cols = sptf_pkg::tile_cols(sel);
   assign rows = sptf_pkg::tile_rows(sel);

   // byte start plus width times height, all in bytes
   assign footprint = {2'b00, attr_c_ff[9:1], 6'b000000}
                    + {4'b0000, 7'(cols * rows), 6'b000000};

   // flip-adjusted tile offsets
   assign hoff = attr_b_ff[12] ? (3'(cols - 4'd1) - col_ff) : col_ff;
   assign voff = attr_b_ff[13] ? (3'(rows - 4'd1) - row_ff) : row_ff;

   // x wraps as 9-bit signed, y folds at the bottom of the screen
   assign x_pos = {{2{attr_b_ff[8]}}, attr_b_ff[8:0]};
   assign y_pos = (attr_a_ff[7:0] >= sptf_pkg::Y_FOLD) ? {3'b111, attr_a_ff[7:0]}
                                                       : {3'b000, attr_a_ff[7:0]};
   assign px = x_pos + {5'b00000, hoff, 3'b000};
   assign py = y_pos + {5'b00000, voff, 3'b000};

   assign culled = (px >= sptf_pkg::SCREEN_W) || (px <= -11'sd8)
                || (py >= sptf_pkg::SCREEN_H) || (py <= -11'sd8);

   // tile number: base plus row times width plus column
   assign row_off  = {4'b0000, row_ff} * {3'b000, cols};
   assign tile_idx = attr_c_ff[9:1] + {2'b00, row_off} + {6'b000000, col_ff};

   assign out_free = !rsp_valid_ff || rsp_ready;

   // status back to the controller
   always_comb begin
      sts.aborted    = aborted_ff;
      sts.skip       = (attr_c_ff & sptf_pkg::SKIP_MASK) != 16'h0000;
      sts.bad_shape  = attr_a_ff[15:14] == sptf_pkg::SHAPE_PROHIBITED;
      sts.too_big    = {1'b0, footprint} > VramLimit;
      sts.lof        = lof_ff;
      sts.visible    = ((attr_a_ff & sptf_pkg::NOCULL_MASK) != 16'h0000) || !culled;
      sts.over_limit = ({1'b0, count_ff} >= TileLimit) || (item_n_ff >= sptf_pkg::TILE_CAP);
      sts.walk_last  = ({1'b0, row_ff} == rows - 4'd1) && ({1'b0, col_ff} == cols - 4'd1);
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = out_free;
   end

   // latch the entry
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         attr_a_ff <= req_data.attr_y_shape;
         attr_b_ff <= req_data.attr_x_size;
         attr_c_ff <= req_data.attr_tile;
         lof_ff    <= req_data.last_of_frame;
      end
   end

   // frame count, abort flag and per-entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         aborted_ff <= 1'b0;
         item_n_ff  <= '0;
      end else begin
         if (cmd.accept) begin
            item_n_ff <= '0;
            if (req_data.first_of_frame) begin
               count_ff   <= '0;
               aborted_ff <= 1'b0;
            end
         end
         if (cmd.set_abort) begin
            aborted_ff <= 1'b1;
         end
         if (cmd.take_tile) begin
            count_ff  <= count_ff + 6'd1;
            item_n_ff <= item_n_ff + 6'd1;
         end
      end
   end

   // advance row-major over the footprint
   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (cmd.advance) begin
         if ({1'b0, col_ff} == cols - 4'd1) begin
            col_ff <= '0;
            row_ff <= row_ff + 3'd1;
         end else begin
            col_ff <= col_ff + 3'd1;
         end
      end
   end

   // pending stage holds the newest tile until its last flag is known
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.take_tile) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.push_pend) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_tile) begin
         pend_index_ff <= tile_idx;
         pend_slot_ff  <= count_ff[4:0];
      end
   end

   // select the word for the output register
   always_comb begin
      push_out    = (cmd.take_tile && pend_valid_ff) || cmd.push_pend || cmd.push_frame;
      rsp_data_in = rsp_data_ff;
      if (cmd.push_frame) begin
         rsp_data_in.kind       = aborted_ff ? sptf_pkg::KIND_ABORT : sptf_pkg::KIND_DONE;
         rsp_data_in.tile_index = '0;
         rsp_data_in.tile_slot  = '0;
         rsp_data_in.tile_total = count_ff;
         rsp_data_in.last       = 1'b1;
      end else if (push_out) begin
         rsp_data_in.kind       = sptf_pkg::KIND_TILE;
         rsp_data_in.tile_index = pend_index_ff;
         rsp_data_in.tile_slot  = pend_slot_ff;
         rsp_data_in.tile_total = '0;
         rsp_data_in.last       = cmd.push_pend && cmd.push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/sprite_tile_footprint_lister.sv =====
// Sprite tile footprint lister. Each request word is one sprite attribute entry
// (three 16-bit words plus frame marks); each response word is a visible tile's
// 64-byte tile number with its slot in the frame list, or, after the entry that
// carries last_of_frame, a completed or aborted frame result with the tile
// total. One entry is handled at a time: the block latches it, checks
// skip, shape and footprint, then walks each 8x8 tile position of the
// sprite (1 to 64, from the shape/size table), then drains the last tile
// and the frame result. The walk holds while the pending tile cannot move
// on because the response channel is stalled. The newest tile waits in a
// pending stage until it is known whether it is the entry's final response.
// A new entry is taken while a response still waits in the output register.
module sprite_tile_footprint_lister #(
   parameter int MAX_TILES  = 32,
   parameter int VRAM_BYTES = 32768
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sptf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sptf_pkg::rsp_type rsp_data
);

   sptf_pkg::cmd_type cmd;
   sptf_pkg::sts_type sts;

   sptf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sptf_datapath #(
      .MAX_TILES  (MAX_TILES),
      .VRAM_BYTES (VRAM_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
